FILE: src/acfp_pkg.sv
// acfp_pkg: constants, result beat type and hex decode for the ascii can frame parser
// depends on nothing; used by ascii_can_frame_parser_core
package acfp_pkg;

   // payload limit in bytes, 1..8
   localparam int MaxPayloadBytes = 8;
   // data bytes carried by a result beat, fixed by the port list
   localparam int StoreDepth = 8;
   localparam int StoreIdxW = $clog2(StoreDepth);
   localparam int IdDigits = 8;
   localparam logic [3:0] ID_DIGITS = 4'(IdDigits);
   localparam logic [4:0] NIBBLE_LIMIT = 5'(2 * MaxPayloadBytes);

   // framing characters
   localparam logic [7:0] CHAR_COLON = 8'h3a;
   localparam logic [7:0] CHAR_X_UP = 8'h58;
   localparam logic [7:0] CHAR_X_LO = 8'h78;
   localparam logic [7:0] CHAR_N_UP = 8'h4e;
   localparam logic [7:0] CHAR_N_LO = 8'h6e;
   localparam logic [7:0] CHAR_SEMI = 8'h3b;

   typedef struct packed {
      logic        ok;
      logic [3:0]  value;
   } hex_type;

   typedef struct packed {
      logic [31:0]                 frame_id;
      logic [3:0]                  byte_count;
      logic [StoreDepth-1:0][7:0]  data;
   } rsp_type;

   // ascii hex digit, either case
   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h.ok = 1'b1;
      h.value = 4'h0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.value = 4'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         h.value = 4'(c - 8'h37);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         h.value = 4'(c - 8'h57);
      end else begin
         h.ok = 1'b0;
      end
      return h;
   endfunction

endpackage

FILE: src/ascii_can_frame_parser_core.sv
// ascii_can_frame_parser_core: extended can frame recognizer for ascii text streams
// depends on acfp_pkg for constants, the result beat type and hex decode
//
// usage:
//   req channel: one ascii character per beat (req_char_in), taken at an edge with
//   req_valid high and req_stall low
//   rsp channel: one beat per complete frame ":X<8 hex id>N<0..16 hex data>;"
//   carrying the identifier, byte count and eight data bytes (unused bytes zero)
//   malformed characters drop the frame silently, no beat is produced
// result: the beat built on an accepted ';' is registered into the result register,
//   or into the skid stage when the result register is held by rsp_stall
// throughput: one character per cycle while req_stall is low
// stall: the result register is backed by a one-beat skid stage, so characters keep
//   flowing while a result waits; req_stall rises only when the skid stage is also
//   full, and drops as soon as the receiver takes a beat
// reset: synchronous, active high; parser returns to idle and both result slots
//   empty; the payload byte store is not cleared, only bytes written in the
//   current frame are ever read
module ascii_can_frame_parser_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_frame_id,
   output logic [3:0]  rsp_byte_count,
   output logic [7:0]  rsp_data_byte0,
   output logic [7:0]  rsp_data_byte1,
   output logic [7:0]  rsp_data_byte2,
   output logic [7:0]  rsp_data_byte3,
   output logic [7:0]  rsp_data_byte4,
   output logic [7:0]  rsp_data_byte5,
   output logic [7:0]  rsp_data_byte6,
   output logic [7:0]  rsp_data_byte7
);

   // parse phases
   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_COLON = 2'd1;
   localparam logic [1:0] PH_ID    = 2'd2;
   localparam logic [1:0] PH_DATA  = 2'd3;

   // parser state
   logic [1:0]  phase_ff, phase_in;
   logic [3:0]  id_count_ff, id_count_in;
   logic [31:0] id_accum_ff, id_accum_in;
   logic        id_bad_ff, id_bad_in;
   logic [4:0]  nibble_ff, nibble_in;

   // payload byte store, no reset
   logic [7:0]  store_ff [acfp_pkg::StoreDepth];
   logic        store_we;
   logic [acfp_pkg::StoreIdxW-1:0] store_idx;
   logic [7:0]  store_wdata;

   // result register and skid stage
   logic                 out_valid_ff, out_valid_in;
   acfp_pkg::rsp_type    out_ff, out_in;
   logic                 skid_valid_ff, skid_valid_in;
   acfp_pkg::rsp_type    skid_ff, skid_in;

   logic                 accept;
   logic                 emit;
   acfp_pkg::rsp_type    result;
   acfp_pkg::hex_type    hex;
   logic [3:0]           nbytes;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign hex       = acfp_pkg::hex_decode(req_char_in);
   assign store_idx = nibble_ff[acfp_pkg::StoreIdxW:1];
   assign nbytes    = nibble_ff[4:1];

   // result beat built from the current state; only used when emit is set
   always_comb begin
      result.frame_id   = id_accum_ff;
      result.byte_count = nbytes;
      for (int k = 0; k < acfp_pkg::StoreDepth; k++) begin
         result.data[k] = (4'(k) < nbytes) ? store_ff[k] : 8'h00;
      end
   end

   // per-character parse step
   always_comb begin
      phase_in    = phase_ff;
      id_count_in = id_count_ff;
      id_accum_in = id_accum_ff;
      id_bad_in   = id_bad_ff;
      nibble_in   = nibble_ff;
      store_we    = 1'b0;
      store_wdata = {hex.value, 4'h0};
      emit        = 1'b0;
      if (accept) begin
         unique case (phase_ff)
            PH_IDLE: begin
               phase_in = (req_char_in == acfp_pkg::CHAR_COLON) ? PH_COLON : PH_IDLE;
            end
            PH_COLON: begin
               if (req_char_in == acfp_pkg::CHAR_X_UP || req_char_in == acfp_pkg::CHAR_X_LO) begin
                  phase_in    = PH_ID;
                  id_count_in = 4'd0;
                  id_accum_in = 32'h0;
                  id_bad_in   = 1'b0;
                  nibble_in   = 5'd0;
               end else begin
                  phase_in = (req_char_in == acfp_pkg::CHAR_COLON) ? PH_COLON : PH_IDLE;
               end
            end
            PH_ID: begin
               if (id_count_ff < acfp_pkg::ID_DIGITS) begin
                  // non-hex digit marks the id bad and shifts in a zero nibble
                  id_accum_in = {id_accum_ff[27:0], hex.ok ? hex.value : 4'h0};
                  id_bad_in   = id_bad_ff | !hex.ok;
                  id_count_in = id_count_ff + 4'd1;
               end else if (req_char_in == acfp_pkg::CHAR_N_UP ||
                            req_char_in == acfp_pkg::CHAR_N_LO) begin
                  phase_in = PH_DATA;
               end else begin
                  phase_in    = PH_IDLE;
                  id_count_in = 4'd0;
                  nibble_in   = 5'd0;
               end
            end
            PH_DATA: begin
               if (req_char_in == acfp_pkg::CHAR_SEMI) begin
                  // frame closes here either way
                  emit = !nibble_ff[0] && !id_bad_ff && (id_count_ff == acfp_pkg::ID_DIGITS);
                  phase_in    = PH_IDLE;
                  id_count_in = 4'd0;
                  nibble_in   = 5'd0;
               end else if (nibble_ff >= acfp_pkg::NIBBLE_LIMIT || !hex.ok) begin
                  phase_in    = PH_IDLE;
                  id_count_in = 4'd0;
                  nibble_in   = 5'd0;
               end else begin
                  // high nibble opens a byte, low nibble fills it
                  store_we    = 1'b1;
                  store_wdata = nibble_ff[0] ? (store_ff[store_idx] | {4'h0, hex.value})
                                             : {hex.value, 4'h0};
                  nibble_in   = nibble_ff + 5'd1;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   // result register with skid stage behind it
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = emit;
            if (emit) begin
               out_in = result;
            end
         end
      end else if (emit) begin
         skid_valid_in = 1'b1;
         skid_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         id_count_ff   <= 4'd0;
         id_accum_ff   <= 32'h0;
         id_bad_ff     <= 1'b0;
         nibble_ff     <= 5'd0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         id_count_ff   <= id_count_in;
         id_accum_ff   <= id_accum_in;
         id_bad_ff     <= id_bad_in;
         nibble_ff     <= nibble_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
      if (store_we) begin
         store_ff[store_idx] <= store_wdata;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_frame_id   = out_ff.frame_id;
   assign rsp_byte_count = out_ff.byte_count;
   assign rsp_data_byte0 = out_ff.data[0];
   assign rsp_data_byte1 = out_ff.data[1];
   assign rsp_data_byte2 = out_ff.data[2];
   assign rsp_data_byte3 = out_ff.data[3];
   assign rsp_data_byte4 = out_ff.data[4];
   assign rsp_data_byte5 = out_ff.data[5];
   assign rsp_data_byte6 = out_ff.data[6];
   assign rsp_data_byte7 = out_ff.data[7];

   // skid stage only fills behind a held result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage full while result register empty");

   // data phase is only reached with a complete identifier
   a_data_after_id: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (id_count_ff == acfp_pkg::ID_DIGITS))
      else $error("data phase entered with short identifier");

   // nibble count never passes the payload limit
   a_nibble_limit: assert property (@(posedge clock) disable iff (reset)
      nibble_ff <= acfp_pkg::NIBBLE_LIMIT)
      else $error("nibble count beyond payload limit");

   // a result beat never claims more bytes than the payload limit
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_byte_count <= 4'(acfp_pkg::MaxPayloadBytes)))
      else $error("byte count beyond payload limit");

endmodule

FILE: sim/tb.sv
// tb: self-checking bench for ascii_can_frame_parser_core, directed table then random frames
// depends on acfp_pkg for the result beat type, framing characters and payload limits
`timescale 1ns / 1ps

module tb;

   // parser phases of the bench's own frame decoder
   typedef enum logic [1:0] {
      PH_IDLE,
      PH_COLON,
      PH_IDENT,
      PH_DATA
   } phase_type;

   // ways a random frame is damaged on its way to the block
   typedef enum int {
      DMG_NONE,
      DMG_CORRUPT,
      DMG_ODD,
      DMG_LONG,
      DMG_DROP,
      DMG_BAD_ID
   } damage_type;

   localparam int HoldCycles = 300;   // long receiver hold-off
   localparam int QuietLimit = 4000;  // cycles with no beat before giving up
   localparam int TailCycles = 6;     // settle time after the last result
   localparam int TargetChars = 1950;
   localparam int CalmChars = 1700;   // from here on both sides run without idling

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_char_in = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_frame_id;
   logic [3:0]  rsp_byte_count;
   logic [7:0]  rsp_data_byte0;
   logic [7:0]  rsp_data_byte1;
   logic [7:0]  rsp_data_byte2;
   logic [7:0]  rsp_data_byte3;
   logic [7:0]  rsp_data_byte4;
   logic [7:0]  rsp_data_byte5;
   logic [7:0]  rsp_data_byte6;
   logic [7:0]  rsp_data_byte7;

   ascii_can_frame_parser_core u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_char_in    (req_char_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_frame_id   (rsp_frame_id),
      .rsp_byte_count (rsp_byte_count),
      .rsp_data_byte0 (rsp_data_byte0),
      .rsp_data_byte1 (rsp_data_byte1),
      .rsp_data_byte2 (rsp_data_byte2),
      .rsp_data_byte3 (rsp_data_byte3),
      .rsp_data_byte4 (rsp_data_byte4),
      .rsp_data_byte5 (rsp_data_byte5),
      .rsp_data_byte6 (rsp_data_byte6),
      .rsp_data_byte7 (rsp_data_byte7)
   );

   always #4 clock = ~clock;

   // expected frames, oldest first
   acfp_pkg::rsp_type frames_due[$];
   int      errors = 0;
   int      chars_sent = 0;
   bit      idle_on = 1'b0;
   bit      hold_req = 1'b0;

   // handshake and payload sampled mid-cycle, where nothing moves; the
   // posedge processes below act on these, so no race with the block
   bit      req_take = 1'b0;
   bit      rsp_take = 1'b0;
   bit      in_reset = 1'b1;
   acfp_pkg::rsp_type rsp_seen;

   always @(negedge clock) begin
      in_reset = reset;
      req_take = req_valid && !req_stall;
      rsp_take = rsp_valid && !rsp_stall;
      rsp_seen.frame_id = rsp_frame_id;
      rsp_seen.byte_count = rsp_byte_count;
      rsp_seen.data = {rsp_data_byte7, rsp_data_byte6, rsp_data_byte5, rsp_data_byte4,
                       rsp_data_byte3, rsp_data_byte2, rsp_data_byte1, rsp_data_byte0};
   end

   // ---------------------------------------------------------------------
   // frame decoder: the bench's own view of what the block must produce
   // ---------------------------------------------------------------------
   phase_type   p_phase;
   logic [3:0]  p_digits;     // identifier characters taken
   logic [31:0] p_ident;
   logic        p_id_bad;
   logic [4:0]  p_nibbles;    // data nibbles taken
   logic [7:0]  p_bytes [acfp_pkg::StoreDepth];

   task automatic decoder_clear();
      p_phase = PH_IDLE;
      p_digits = '0;
      p_nibbles = '0;
   endtask

   // {ok, value} for an ascii hex digit of either case
   function automatic logic [4:0] nibble_of(input logic [7:0] c);
      if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
      if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
      if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
      return 5'b0_0000;
   endfunction

   task automatic parse_char(input logic [7:0] c, output bit emit,
                             output acfp_pkg::rsp_type frame);
      logic [4:0] h;
      logic [3:0] nbytes;
      emit = 1'b0;
      frame = '0;
      h = nibble_of(c);
      case (p_phase)
         PH_IDLE: begin
            p_phase = (c == acfp_pkg::CHAR_COLON) ? PH_COLON : PH_IDLE;
         end
         PH_COLON: begin
            if (c == acfp_pkg::CHAR_X_UP || c == acfp_pkg::CHAR_X_LO) begin
               p_phase = PH_IDENT;
               p_digits = '0;
               p_ident = '0;
               p_id_bad = 1'b0;
               p_nibbles = '0;
            end else begin
               // a repeated colon keeps waiting for the x
               p_phase = (c == acfp_pkg::CHAR_COLON) ? PH_COLON : PH_IDLE;
            end
         end
         PH_IDENT: begin
            if (p_digits < acfp_pkg::ID_DIGITS) begin
               // any character counts as a digit; non-hex ones poison the id
               if (!h[4]) p_id_bad = 1'b1;
               p_ident = {p_ident[27:0], h[4] ? h[3:0] : 4'h0};
               p_digits = p_digits + 4'd1;
            end else if (c == acfp_pkg::CHAR_N_UP || c == acfp_pkg::CHAR_N_LO) begin
               p_phase = PH_DATA;
            end else begin
               decoder_clear();
            end
         end
         PH_DATA: begin
            if (c == acfp_pkg::CHAR_SEMI) begin
               if (!p_nibbles[0] && !p_id_bad && p_digits == acfp_pkg::ID_DIGITS) begin
                  nbytes = p_nibbles[4:1];
                  emit = 1'b1;
                  frame.frame_id = p_ident;
                  frame.byte_count = nbytes;
                  for (int k = 0; k < acfp_pkg::StoreDepth; k++) begin
                     frame.data[k] = (k < nbytes) ? p_bytes[k] : 8'h00;
                  end
               end
               decoder_clear();
            end else if (p_nibbles >= acfp_pkg::NIBBLE_LIMIT || !h[4]) begin
               // payload overflow or a non-hex data digit
               decoder_clear();
            end else begin
               if (!p_nibbles[0]) p_bytes[p_nibbles[3:1]] = {h[3:0], 4'h0};
               else p_bytes[p_nibbles[3:1]][3:0] = h[3:0];
               p_nibbles = p_nibbles + 5'd1;
            end
         end
      endcase
   endtask

   // ---------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------
   // offer one character beat, hold it until taken, then log what it causes;
   // a fixed frame stands in for the decoder's when a table row types one in
   task automatic send_char(input logic [7:0] c, input bit fixed,
                            input acfp_pkg::rsp_type fixed_frame);
      int      gap;
      bit      emit;
      acfp_pkg::rsp_type frame;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 5);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_char_in <= c;
      do @(posedge clock); while (!req_take);
      chars_sent++;
      parse_char(c, emit, frame);
      if (emit) frames_due.push_back(fixed ? fixed_frame : frame);
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) return 8'(v) + "0";
      return ($urandom_range(0, 1) ? "A" : "a") + 8'(v - 4'd10);
   endfunction

   // one frame with random content, optionally damaged, with optional line noise ahead
   task automatic send_frame(input damage_type dmg, input int max_bytes);
      logic [7:0]  txt[$];
      logic [31:0] ident;
      int          nbytes;
      int          extra;
      int          pos;
      logic [7:0]  c;
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(0, 255)), 1'b0, '0);
      end
      ident = $urandom;
      nbytes = $urandom_range(0, max_bytes);
      extra = 0;
      if (dmg == DMG_ODD) extra = 1;
      if (dmg == DMG_LONG) extra = 2 * acfp_pkg::MaxPayloadBytes + 1 - 2 * nbytes;
      txt.push_back(acfp_pkg::CHAR_COLON);
      txt.push_back($urandom_range(0, 1) ? acfp_pkg::CHAR_X_UP : acfp_pkg::CHAR_X_LO);
      for (int i = 7; i >= 0; i--) txt.push_back(hex_char(ident[4*i +: 4]));
      txt.push_back($urandom_range(0, 1) ? acfp_pkg::CHAR_N_UP : acfp_pkg::CHAR_N_LO);
      repeat (2 * nbytes + extra) txt.push_back(hex_char(4'($urandom_range(0, 15))));
      txt.push_back(acfp_pkg::CHAR_SEMI);
      pos = (dmg == DMG_BAD_ID) ? $urandom_range(2, 9) : $urandom_range(0, txt.size() - 1);
      for (int i = 0; i < txt.size(); i++) begin
         c = txt[i];
         if (i == pos && dmg == DMG_CORRUPT) c = 8'($urandom_range(0, 255));
         // 0x67..0x7f holds no hex digit
         if (i == pos && dmg == DMG_BAD_ID) c = 8'($urandom_range(8'h67, 8'h7f));
         if (!(i == pos && dmg == DMG_DROP)) begin
            send_char(c, 1'b0, '0);
         end
      end
   endtask

   // sender stands back until every expected frame is out
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (frames_due.size() != 0) @(posedge clock);
      repeat (TailCycles) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // response side: random stall bursts plus one long hold-off on request
   // ---------------------------------------------------------------------
   int stall_left = 0;

   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
      end else if (hold_req) begin
         hold_req = 1'b0;
         stall_left = HoldCycles;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 5);
      end
      rsp_stall <= (stall_left != 0);
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endtask

   // every taken result beat against the oldest expectation
   always @(posedge clock) begin
      acfp_pkg::rsp_type want;
      if (!in_reset && rsp_take) begin
         if (frames_due.size() == 0) begin
            $error("result beat with no frame expected, frame_id %0h", rsp_seen.frame_id);
            errors++;
         end else begin
            want = frames_due.pop_front();
            check_field("frame_id", want.frame_id, rsp_seen.frame_id);
            check_field("byte_count", 32'(want.byte_count), 32'(rsp_seen.byte_count));
            for (int k = 0; k < acfp_pkg::StoreDepth; k++) begin
               check_field($sformatf("data_byte%0d", k), 32'(want.data[k]),
                           32'(rsp_seen.data[k]));
            end
         end
      end
   end

   // watchdog on stretches with no beat on either channel
   int quiet = 0;

   always @(posedge clock) begin
      if (in_reset || req_take || rsp_take) quiet = 0;
      else quiet++;
      if (quiet >= QuietLimit) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // directed table: text of each row, and the frame typed in where obvious
   // ---------------------------------------------------------------------
   string   row_text[$];
   bit      row_fixed[$];
   acfp_pkg::rsp_type row_frame[$];

   task automatic add_row(input string text, input bit fixed, input acfp_pkg::rsp_type frame);
      row_text.push_back(text);
      row_fixed.push_back(fixed);
      row_frame.push_back(frame);
   endtask

   initial begin
      logic [7:0] raw [4];
      string      text;
      damage_type dmg;
      int         pick;

      raw = '{8'h00, 8'hff, 8'h80, 8'h7f};
      decoder_clear();
      p_ident = '0;
      p_id_bad = 1'b0;
      foreach (p_bytes[k]) p_bytes[k] = 8'h00;

      // empty payload, all-zero id
      add_row(":X00000000N;", 1'b1, acfp_pkg::rsp_type'({32'h0000_0000, 4'd0, 64'h0}));
      // full payload, all-ones id, lower-case x and n, both letter cases in data
      add_row(":xFFFFFFFFn0123456789abCDEF;", 1'b1,
              acfp_pkg::rsp_type'({32'hffff_ffff, 4'd8, 64'hefcd_ab89_6745_2301}));
      // bad identifier digit, no frame
      add_row(":X1234567GN00;", 1'b0, '0);
      // odd data digit count, no frame
      add_row(":X12345678N0;", 1'b0, '0);
      // too many data digits, no frame
      add_row(":X12345678N001122334455667788;", 1'b0, '0);
      // non-hex data digit, no frame
      add_row(":X12345678NZZ;", 1'b0, '0);
      // repeated colon before the x still starts a frame
      add_row("::x89abcdefN7f;", 1'b1, acfp_pkg::rsp_type'({32'h89ab_cdef, 4'd1, 64'h7f}));
      // wrong letter after colon, stray text while idle
      add_row(":Aq;", 1'b0, '0);
      // ninth identifier character not n
      add_row(":X12345678M00;", 1'b0, '0);
      // mixed-case id, checked by the decoder
      add_row(":XdeadBEEFNa5c3;", 1'b0, '0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      idle_on = 1'b1;

      // byte extremes on an idle parser
      foreach (raw[i]) send_char(raw[i], 1'b0, '0);
      foreach (row_text[r]) begin
         text = row_text[r];
         for (int i = 0; i < text.len(); i++) send_char(text[i], row_fixed[r], row_frame[r]);
      end

      // long receiver hold-off while short frames keep coming, so input stalls
      hold_req = 1'b1;
      repeat (8) send_frame(DMG_NONE, 1);
      wait_drained();

      // random frames, mostly well formed
      while (chars_sent < TargetChars) begin
         if (chars_sent >= CalmChars) idle_on = 1'b0;
         pick = $urandom_range(0, 99);
         if (pick < 70) dmg = DMG_NONE;
         else if (pick < 76) dmg = DMG_CORRUPT;
         else if (pick < 82) dmg = DMG_ODD;
         else if (pick < 88) dmg = DMG_LONG;
         else if (pick < 94) dmg = DMG_DROP;
         else dmg = DMG_BAD_ID;
         send_frame(dmg, acfp_pkg::MaxPayloadBytes);
      end

      wait_drained();
      errors += frames_due.size();
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: ascii_can_frame_parser_core.f
src/acfp_pkg.sv
src/ascii_can_frame_parser_core.sv
sim/tb.sv
